// ===== rtl/core/lrt_pkg.sv =====
// Package for the learning route table: payload structs, the word that
// travels down the cell chain, register indexes and the broadcast id list.
// No dependencies.
`default_nettype none

package lrt_pkg;

  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_TTL      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEANUP_PERIOD = 8'd1;

  localparam logic [31:0] TTL_RESET    = 32'd10000;
  localparam logic [7:0]  PERIOD_RESET = 8'd10;

  localparam logic       OP_ROUTE = 1'b0;
  localparam logic       OP_LEARN = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic        is_mavlink;
    logic [7:0]  sender_sys;
    logic        src_valid;
    logic [2:0]  src_interface;
    logic [15:0] msg_id;
    logic [7:0]  target_sys;
    logic [31:0] now_ms;
    logic        batch_end;
  } lrt_in_t;

  typedef struct packed {
    logic        explicit_target;
    logic [7:0]  target_devices;
    logic [31:0] hit_total;
    logic [31:0] broadcast_total;
  } lrt_out_t;

  // Word handed from cell to cell. The first pass merges into a matching
  // entry; the second pass fills the first free slot, gathers the route
  // mask and frees expired entries.
  typedef struct packed {
    logic        vld;
    logic        pass_b;
    logic        learn;
    logic        hit;
    logic        route;
    logic        sweep;
    logic [7:0]  sys;
    logic [7:0]  iface_bit;
    logic [7:0]  target;
    logic [31:0] now;
    logic [7:0]  acc;
  } lrt_word_t;

  function automatic logic is_bcast_id(input logic [15:0] id);
    logic r;
    r = (id == 16'd0)  || (id == 16'd1)  || (id == 16'd22) ||
        (id == 16'd30) || (id == 16'd33) || (id == 16'd42) ||
        (id == 16'd74) || (id == 16'd77) || (id == 16'd253);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lrt_cell.sv =====
// One table entry of the learning route table with its slice of the chain.
// Depends on lrt_pkg for the chain word type.
`default_nettype none

module lrt_cell import lrt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] ttl,
  input  lrt_word_t   word_in,
  output lrt_word_t   word_out
);

  logic        active_r, active_nxt;
  logic [7:0]  sys_r, sys_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [31:0] seen_r, seen_nxt;
  lrt_word_t   word_r, word_nxt;
  logic [31:0] age;
  logic        expired;

  always_comb begin
    active_nxt = active_r;
    sys_nxt    = sys_r;
    mask_nxt   = mask_r;
    seen_nxt   = seen_r;
    word_nxt   = word_in;
    age        = 32'd0;
    expired    = 1'b0;
    if (word_in.vld) begin
      if (!word_in.pass_b) begin
        if (word_in.learn && !word_in.hit && active_r && (sys_r == word_in.sys)) begin
          mask_nxt     = mask_r | word_in.iface_bit;
          seen_nxt     = word_in.now;
          word_nxt.hit = 1'b1;
        end
      end else begin
        // The first free slot takes the sender when no entry matched.
        if (word_in.learn && !word_in.hit && !active_r) begin
          active_nxt   = 1'b1;
          sys_nxt      = word_in.sys;
          mask_nxt     = word_in.iface_bit;
          seen_nxt     = word_in.now;
          word_nxt.hit = 1'b1;
        end
        age     = word_in.now - seen_nxt;
        expired = age > ttl;
        if (word_in.route && active_nxt && !expired && (sys_nxt == word_in.target)) begin
          word_nxt.acc = word_in.acc | mask_nxt;
        end
        if (word_in.sweep && active_nxt && expired) begin
          active_nxt = 1'b0;
          mask_nxt   = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      sys_r      <= 8'd0;
      mask_r     <= 8'd0;
      seen_r     <= 32'd0;
      word_r     <= '0;
    end else begin
      active_r   <= active_nxt;
      sys_r      <= sys_nxt;
      mask_r     <= mask_nxt;
      seen_r     <= seen_nxt;
      word_r     <= word_nxt;
    end
  end

  assign word_out = word_r;

endmodule

`default_nettype wire

// ===== rtl/core/learning_route_table.sv =====
// Learning route table: a chain of TABLE_ENTRIES cells, one entry each.
// An accepted input is registered into the launch register, walks the chain
// through every cell register, is launched again from the tail for a second
// walk, and its tail is captured before the output register takes the result.
// A new input is taken only in the idle state, once the previous result has
// gone to the output register; a finished result waits for out_ready.
// Reset (synchronous, rst_n low) clears every entry, both counters and the
// batch count, and loads the register reset values; no clearing pass follows.
`default_nettype none

module learning_route_table import lrt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lrt_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lrt_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_FIN} state_t;

  state_t      state_r, state_nxt;
  logic [31:0] ttl_r, ttl_nxt;
  logic [7:0]  period_r, period_nxt;
  logic [7:0]  batch_r, batch_nxt;
  logic [31:0] hit_r, hit_nxt;
  logic [31:0] bcast_r, bcast_nxt;
  logic        route_r, route_nxt;
  logic        bdir_r, bdir_nxt;
  logic [7:0]  acc_r, acc_nxt;
  lrt_word_t   launch_r, launch_nxt;
  logic        out_valid_r, out_valid_nxt;
  lrt_out_t    out_data_r, out_data_nxt;

  lrt_word_t   chain [0:TABLE_ENTRIES];
  lrt_word_t   tail;
  logic        in_acc;
  logic        mav_route;
  logic [8:0]  batch_inc;
  logic        do_sweep;
  logic        onehot;

  assign chain[0] = launch_r;
  assign tail     = chain[TABLE_ENTRIES];

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    lrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ttl      (ttl_r),
      .word_in  (chain[g]),
      .word_out (chain[g+1])
    );
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign mav_route = (in_data.opcode == OP_ROUTE) && in_data.is_mavlink;
  assign batch_inc = {1'b0, batch_r} + 9'd1;
  assign do_sweep  = (in_data.opcode == OP_ROUTE) && in_data.batch_end &&
                     (batch_inc >= {1'b0, period_r});
  assign onehot    = (acc_r != 8'd0) && ((acc_r & (acc_r - 8'd1)) == 8'd0);

  always_comb begin
    state_nxt     = state_r;
    ttl_nxt       = ttl_r;
    period_nxt    = period_r;
    batch_nxt     = batch_r;
    hit_nxt       = hit_r;
    bcast_nxt     = bcast_r;
    route_nxt     = route_r;
    bdir_nxt      = bdir_r;
    acc_nxt       = acc_r;
    launch_nxt    = launch_r;
    launch_nxt.vld = 1'b0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_ENTRY_TTL) begin
        ttl_nxt = cfg_data;
      end else if (cfg_index == CFG_CLEANUP_PERIOD) begin
        period_nxt = cfg_data[7:0];
      end
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          launch_nxt.vld       = 1'b1;
          launch_nxt.pass_b    = 1'b0;
          launch_nxt.learn     = ((in_data.opcode == OP_LEARN) || in_data.is_mavlink) &&
                                 (in_data.sender_sys != 8'd0) && in_data.src_valid;
          launch_nxt.hit       = 1'b0;
          launch_nxt.route     = mav_route && !is_bcast_id(in_data.msg_id) &&
                                 (in_data.target_sys != 8'd0);
          launch_nxt.sweep     = do_sweep;
          launch_nxt.sys       = in_data.sender_sys;
          launch_nxt.iface_bit = 8'd1 << in_data.src_interface;
          launch_nxt.target    = in_data.target_sys;
          launch_nxt.now       = in_data.now_ms;
          launch_nxt.acc       = 8'd0;
          route_nxt            = launch_nxt.route;
          bdir_nxt             = mav_route && !launch_nxt.route;
          if ((in_data.opcode == OP_ROUTE) && in_data.batch_end) begin
            batch_nxt = do_sweep ? 8'd0 : batch_inc[7:0];
          end
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (tail.vld && !tail.pass_b) begin
          // First walk done: send the word around again for fill, lookup and sweep.
          launch_nxt        = tail;
          launch_nxt.pass_b = 1'b1;
        end else if (tail.vld) begin
          acc_nxt   = tail.acc;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.explicit_target = route_r && onehot;
          out_data_nxt.target_devices  = (route_r && onehot) ? acc_r : 8'd0;
          if (route_r && onehot) begin
            hit_nxt = hit_r + 32'd1;
          end else if (route_r || bdir_r) begin
            bcast_nxt = bcast_r + 32'd1;
          end
          out_data_nxt.hit_total       = hit_nxt;
          out_data_nxt.broadcast_total = bcast_nxt;
          state_nxt                    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ttl_r       <= TTL_RESET;
      period_r    <= PERIOD_RESET;
      batch_r     <= 8'd0;
      hit_r       <= 32'd0;
      bcast_r     <= 32'd0;
      route_r     <= 1'b0;
      bdir_r      <= 1'b0;
      acc_r       <= 8'd0;
      launch_r    <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      ttl_r       <= ttl_nxt;
      period_r    <= period_nxt;
      batch_r     <= batch_nxt;
      hit_r       <= hit_nxt;
      bcast_r     <= bcast_nxt;
      route_r     <= route_nxt;
      bdir_r      <= bdir_nxt;
      acc_r       <= acc_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
